// File: rtl/mtd_pkg.sv
// mtd_pkg: shared types, constants and the Morse tree lookup for the tick decoder.
// No dependencies; imported by every other file of the block.
package mtd_pkg;

   localparam int CntW   = 4;
   localparam int PulseW = 16;
   localparam int SymW   = 5;
   localparam int TotW   = 3;
   localparam int CharW  = 8;
   localparam int IdxW   = 3;

   localparam logic [CntW-1:0] CntMax  = 4'd15;
   localparam logic [TotW-1:0] SymMax  = 3'd5;
   localparam logic [CharW-1:0] ChrSpace = 8'h20;
   localparam logic [CharW-1:0] ChrDash  = 8'h2D;

   typedef enum logic [IdxW-1:0] {
      REG_MARK_THRESHOLD = 3'd0,
      REG_DOT_LENGTH     = 3'd1,
      REG_DASH_LENGTH    = 3'd2,
      REG_LETTER_GAP     = 3'd3,
      REG_WORD_GAP       = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [PulseW-1:0] mark_threshold;
      logic [CntW-1:0]   dot_length;
      logic [CntW-1:0]   dash_length;
      logic [CntW-1:0]   letter_gap;
      logic [CntW-1:0]   word_gap;
   } cfg_type;

   typedef struct packed {
      logic [CharW-1:0] char_code;
      logic             is_space;
      logic [TotW-1:0]  symbol_count;
      logic [SymW-1:0]  symbol_bits;
   } result_type;

   localparam logic [CharW-1:0] TreeTab [62] = '{
      "5","H","4","S","-","V","3","I","-","F","-","U","-","-","2","E",
      "-","L","-","R","-","-","-","A","-","P","-","W","-","J","1","6",
      "B","-","D","-","X","-","N","-","C","-","K","-","Y","-","T","7",
      "Z","-","G","-","Q","-","M","8","-","-","O","9","-","0"
   };

   function automatic logic [CharW-1:0] decode_letter(input logic [SymW-1:0] bits,
                                                      input logic [TotW-1:0] count);
      logic [5:0] idx;
      logic [3:0] step;
      idx  = bits[0] ? 6'd47 : 6'd16;
      step = 4'd8;
      for (int k = 1; k < SymW; k++) begin
         if (TotW'(k) < count) begin
            if (bits[k])
               idx = idx + 6'(step);
            else
               idx = idx - 6'(step);
         end
         step = step >> 1;
      end
      if (count == '0 || count > SymMax || idx == '0 || idx > 6'd62)
         return ChrDash;
      return TreeTab[idx - 6'd1];
   endfunction

endpackage

// File: rtl/mtd_if.sv
// mtd_if: valid/ready channel interfaces for ticks, decoded items and register writes.
// Depends on mtd_pkg for field widths.
interface mtd_req_if import mtd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [PulseW-1:0] pulse_count;
   modport source (output valid, output pulse_count, input ready);
   modport sink   (input valid, input pulse_count, output ready);
endinterface

interface mtd_rsp_if import mtd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [CharW-1:0] char_code;
   logic             is_space;
   logic [TotW-1:0]  symbol_count;
   logic [SymW-1:0]  symbol_bits;
   modport source (output valid, output char_code, output is_space,
                   output symbol_count, output symbol_bits, input ready);
   modport sink   (input valid, input char_code, input is_space,
                   input symbol_count, input symbol_bits, output ready);
endinterface

interface mtd_csr_if import mtd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [IdxW-1:0]   index;
   logic [PulseW-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// File: rtl/morse_tick_decoder_core.sv
// Channel | Dir | Payload                                          | Accept
// req_ch  | in  | pulse_count[15:0]                                | valid & ready
// rsp_ch  | out | char_code[7:0] is_space symbol_count[2:0] bits[4:0] | valid & ready
// csr_ch  | in  | index[2:0] data[15:0]                            | valid & ready
// One tick per cycle while the result is not stalled: a tick enters the input
// register, is decoded by the tick logic, and any result lands in the result register.
// Reset restores the register defaults and clears all decode state.
// A stalled result holds its own register and the tick waiting in the input
// register, so the input stalls too; both advance on the edge the result is
// taken.
// Depends on mtd_pkg, mtd_if, mtd_csr and mtd_tick.
module morse_tick_decoder_core import mtd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   mtd_req_if.sink    req_ch,
   mtd_rsp_if.source  rsp_ch,
   mtd_csr_if.sink    csr_ch
);

   cfg_type           cfg;
   logic              in_valid_ff, in_valid_in;
   logic [PulseW-1:0] pulse_ff, pulse_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;
   logic              out_free;
   logic              take;
   logic              res_valid;
   result_type        res;

   mtd_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   mtd_tick u_tick (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .take        (take),
      .pulse_count (pulse_ff),
      .res_valid   (res_valid),
      .res         (res)
   );

   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign take         = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      pulse_in     = pulse_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (req_ch.ready) begin
         in_valid_in = req_ch.valid;
         pulse_in    = req_ch.pulse_count;
      end
      if (out_free) begin
         out_valid_in = take && res_valid;
         out_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      pulse_ff <= pulse_in;
      out_ff   <= out_in;
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.char_code    = out_ff.char_code;
   assign rsp_ch.is_space     = out_ff.is_space;
   assign rsp_ch.symbol_count = out_ff.symbol_count;
   assign rsp_ch.symbol_bits  = out_ff.symbol_bits;

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |=> out_valid_ff && $stable(out_ff))
      else $error("stalled item changed");

   a_no_take_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ch.ready |-> !take)
      else $error("tick consumed while result stalled");

   a_space_fields: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.is_space |-> out_ff.char_code == ChrSpace
         && out_ff.symbol_count == '0)
      else $error("malformed space item");

endmodule

// File: rtl/mtd_csr.sv
// mtd_csr: configuration register file of the tick decoder.
// Depends on mtd_pkg and mtd_csr_if.
module mtd_csr import mtd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   mtd_csr_if.sink   csr_ch,
   output cfg_type   cfg
);

   cfg_type cfg_ff, cfg_in;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (reg_index_type'(csr_ch.index))
            REG_MARK_THRESHOLD: cfg_in.mark_threshold = csr_ch.data;
            REG_DOT_LENGTH:     cfg_in.dot_length     = csr_ch.data[CntW-1:0];
            REG_DASH_LENGTH:    cfg_in.dash_length    = csr_ch.data[CntW-1:0];
            REG_LETTER_GAP:     cfg_in.letter_gap     = csr_ch.data[CntW-1:0];
            REG_WORD_GAP:       cfg_in.word_gap       = csr_ch.data[CntW-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mark_threshold <= 16'd60;
         cfg_ff.dot_length     <= 4'd1;
         cfg_ff.dash_length    <= 4'd3;
         cfg_ff.letter_gap     <= 4'd3;
         cfg_ff.word_gap       <= 4'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/mtd_tick.sv
// mtd_tick: run/gap tracking, symbol collection, letter decode and word spaces for one tick.
// Depends on mtd_pkg.
module mtd_tick import mtd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   input  logic              take,
   input  logic [PulseW-1:0] pulse_count,
   output logic              res_valid,
   output result_type        res
);

   logic            started_ff, started_in;
   logic [CntW-1:0] mark_run_ff, mark_run_in;
   logic [CntW-1:0] gap_run_ff, gap_run_in;
   logic [SymW-1:0] sym_store_ff, sym_store_in;
   logic [TotW-1:0] sym_total_ff, sym_total_in;

   always_comb begin
      logic [SymW-1:0] st;
      logic [TotW-1:0] tot;
      logic [CntW-1:0] g;
      logic            is_dot;
      logic            is_dash;
      started_in   = started_ff;
      mark_run_in  = mark_run_ff;
      gap_run_in   = gap_run_ff;
      sym_store_in = sym_store_ff;
      sym_total_in = sym_total_ff;
      res_valid    = 1'b0;
      res          = '0;
      st           = sym_store_ff;
      tot          = sym_total_ff;
      g            = gap_run_ff + 4'd1;
      is_dot       = mark_run_ff == cfg.dot_length;
      is_dash      = mark_run_ff == cfg.dash_length;
      if (take && (started_ff || pulse_count != '0)) begin
         started_in = 1'b1;
         if (pulse_count > cfg.mark_threshold) begin
            if (mark_run_ff != CntMax)
               mark_run_in = mark_run_ff + 4'd1;
            gap_run_in = '0;
         end else begin
            if (mark_run_ff != '0) begin
               if ((is_dot || is_dash) && tot < SymMax) begin
                  if (!is_dot)
                     st[tot] = 1'b1;
                  tot = tot + 3'd1;
               end
               mark_run_in = '0;
            end
            sym_store_in = st;
            sym_total_in = tot;
            if (gap_run_ff != CntMax) begin
               gap_run_in = g;
               if (g == cfg.letter_gap) begin
                  sym_store_in = '0;
                  sym_total_in = '0;
                  if (tot != '0) begin
                     res_valid        = 1'b1;
                     res.char_code    = decode_letter(st, tot);
                     res.is_space     = 1'b0;
                     res.symbol_count = tot;
                     res.symbol_bits  = st;
                  end
               end
               if (!res_valid && g == cfg.word_gap) begin
                  res_valid        = 1'b1;
                  res.char_code    = ChrSpace;
                  res.is_space     = 1'b1;
                  res.symbol_count = '0;
                  res.symbol_bits  = '0;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff   <= 1'b0;
         mark_run_ff  <= '0;
         gap_run_ff   <= '0;
         sym_store_ff <= '0;
         sym_total_ff <= '0;
      end else begin
         started_ff   <= started_in;
         mark_run_ff  <= mark_run_in;
         gap_run_ff   <= gap_run_in;
         sym_store_ff <= sym_store_in;
         sym_total_ff <= sym_total_in;
      end
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      sym_total_ff <= SymMax)
      else $error("symbol total beyond five");

   a_mark_clears_gap: assert property (@(posedge clock) disable iff (reset)
      mark_run_ff != '0 |-> gap_run_ff == '0)
      else $error("mark run open while gap run nonzero");

   a_idle_before_start: assert property (@(posedge clock) disable iff (reset)
      !started_ff |-> (mark_run_ff == '0 && gap_run_ff == '0 && sym_total_ff == '0))
      else $error("state moved before first edge");

   a_letter_nonempty: assert property (@(posedge clock) disable iff (reset)
      res_valid && !res.is_space |-> res.symbol_count != '0)
      else $error("empty letter emitted");

endmodule
